### sv/eauf_pkg.sv
package eauf_pkg;

    // sample and angle geometry
    localparam int RAW_W    = 12;
    localparam int TURN_W   = 20;
    localparam int ACC_W    = 32;
    localparam int COEF_W   = 16;
    localparam int WARM_W   = 8;
    localparam int SPEED_W  = 21;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_ALPHA    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_ALPHA    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_SAMPLES = 2'd2;

    localparam logic [COEF_W-1:0] ANGLE_ALPHA_RST    = 16'd6554;
    localparam logic [COEF_W-1:0] SPEED_ALPHA_RST    = 16'd6554;
    localparam logic [WARM_W-1:0] WARMUP_SAMPLES_RST = 8'd50;

    // datapath operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_FETCH  = 3'd0;
    localparam logic [OP_W-1:0] OP_UNWRAP = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL_A  = 3'd2;
    localparam logic [OP_W-1:0] OP_ACC_A  = 3'd3;
    localparam logic [OP_W-1:0] OP_WARM   = 3'd4;
    localparam logic [OP_W-1:0] OP_MUL_S  = 3'd5;
    localparam logic [OP_W-1:0] OP_ACC_S  = 3'd6;
    localparam logic [OP_W-1:0] OP_EMIT   = 3'd7;

    // jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_NEVER     = 3'd0;
    localparam logic [COND_W-1:0] C_NO_ACCEPT = 3'd1;
    localparam logic [COND_W-1:0] C_FIRST     = 3'd2;
    localparam logic [COND_W-1:0] C_WARMING   = 3'd3;
    localparam logic [COND_W-1:0] C_OUT_BUSY  = 3'd4;

    // program steps
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] P_FETCH  = 3'd0;
    localparam logic [PC_W-1:0] P_UNWRAP = 3'd1;
    localparam logic [PC_W-1:0] P_MUL_A  = 3'd2;
    localparam logic [PC_W-1:0] P_ACC_A  = 3'd3;
    localparam logic [PC_W-1:0] P_WARM   = 3'd4;
    localparam logic [PC_W-1:0] P_MUL_S  = 3'd5;
    localparam logic [PC_W-1:0] P_ACC_S  = 3'd6;
    localparam logic [PC_W-1:0] P_EMIT   = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } ctrl_t;

    typedef struct packed {
        logic in_accept;
        logic first;
        logic warming;
        logic out_busy;
    } status_t;

    // control store: one control word per step, fall-through is pc + 1
    function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
        ctrl_t w;
        unique case (pc)
            P_FETCH:  w = '{op: OP_FETCH,  cond: C_NO_ACCEPT, target: P_FETCH};
            P_UNWRAP: w = '{op: OP_UNWRAP, cond: C_FIRST,     target: P_WARM};
            P_MUL_A:  w = '{op: OP_MUL_A,  cond: C_NEVER,     target: P_FETCH};
            P_ACC_A:  w = '{op: OP_ACC_A,  cond: C_NEVER,     target: P_FETCH};
            P_WARM:   w = '{op: OP_WARM,   cond: C_WARMING,   target: P_EMIT};
            P_MUL_S:  w = '{op: OP_MUL_S,  cond: C_NEVER,     target: P_FETCH};
            P_ACC_S:  w = '{op: OP_ACC_S,  cond: C_NEVER,     target: P_FETCH};
            P_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_BUSY,  target: P_EMIT};
        endcase
        return w;
    endfunction

endpackage

### sv/eauf_ifs.sv
interface eauf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] angle_high_byte;
    logic [7:0] angle_low_byte;

    modport source (output valid, output angle_high_byte, output angle_low_byte, input ready);
    modport sink   (input valid, input angle_high_byte, input angle_low_byte, output ready);
endinterface

interface eauf_out_if;
    logic               valid;
    logic               ready;
    logic [19:0]        filtered_angle;
    logic signed [20:0] filtered_speed;
    logic               speed_valid;

    modport source (output valid, output filtered_angle, output filtered_speed,
                    output speed_valid, input ready);
    modport sink   (input valid, input filtered_angle, input filtered_speed,
                    input speed_valid, output ready);
endinterface

### sv/eauf_seq.sv
module eauf_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  eauf_pkg::status_t status,
    output eauf_pkg::ctrl_t   ctrl
);
    import eauf_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            cond_hit;

    assign ctrl = ucode(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            C_NO_ACCEPT: cond_hit = !status.in_accept;
            C_FIRST:     cond_hit = status.first;
            C_WARMING:   cond_hit = status.warming;
            C_OUT_BUSY:  cond_hit = status.out_busy;
            default:     cond_hit = 1'b0;
        endcase
    end

    // last step falls through to the fetch step by wrap-around
    assign pc_next = cond_hit ? ctrl.target : pc_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= P_FETCH;
        else
            pc_reg <= pc_next;
    end

endmodule

### sv/encoder_angle_unwrap_filter_top.sv
// channel   dir  handshake        payload
// in_ch     in   valid / ready    angle_high_byte[7:0], angle_low_byte[7:0]
// out_ch    out  valid / ready    filtered_angle[19:0], filtered_speed[20:0] s, speed_valid
// cfg       in   cfg_wr_en        cfg_index[1:0], cfg_wr_data[15:0]
//
// a sample holds the block through fetch, unwrap, angle multiply and accumulate, warm,
// speed multiply and accumulate and emit when speed is estimated; warm-up skips the speed
// steps and a first sample also the angle steps; the result is registered at emit, and no
// new sample is taken first; microcode runs the single shared multiplier once per filter
// reset sets the seed flag, clears the program counter, speed filter, warm-up count and
// output valid, and loads the coefficient defaults; no clearing pass
// a finished result sits in the output register while the next sample is taken;
// the emit step waits only if that register is still full and unread
module encoder_angle_unwrap_filter_top #(
    parameter int ALPHA_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    eauf_in_if.sink                             in_ch,
    eauf_out_if.source                          out_ch,
    input  logic                                cfg_wr_en,
    input  logic [eauf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [eauf_pkg::CFG_DAT_W-1:0]      cfg_wr_data
);
    import eauf_pkg::*;

    localparam int PROD_W = ACC_W + COEF_W + 1;
    localparam int STEP_W = RAW_W + 1;

    // sequencer interface
    ctrl_t   ctrl;
    status_t status;

    // configuration
    logic [COEF_W-1:0] angle_alpha_reg;
    logic [COEF_W-1:0] speed_alpha_reg;
    logic [WARM_W-1:0] warmup_samples_reg;

    // filter state
    logic                      first_reg;
    logic [RAW_W-1:0]          raw_reg;
    logic [RAW_W-1:0]          prev_raw_reg;
    logic [ACC_W-1:0]          unw_reg;
    logic [ACC_W-1:0]          afv_reg;
    logic [TURN_W-1:0]         filt_reg;
    logic [TURN_W-1:0]         prev_filt_reg;
    logic signed [SPEED_W-1:0] sfv_reg;
    logic [WARM_W-1:0]         warm_cnt_reg;
    logic                      spd_ok_reg;

    // shared multiplier operand and product
    logic signed [ACC_W-1:0]  x_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // output register
    logic                      out_valid_reg;
    logic [TURN_W-1:0]         out_angle_reg;
    logic signed [SPEED_W-1:0] out_speed_reg;
    logic                      out_spd_ok_reg;

    logic                      in_accept;
    logic                      out_busy;
    logic                      emit_load;
    logic                      warming;
    logic [RAW_W-1:0]          raw_in;
    logic signed [STEP_W-1:0]  raw_step;
    logic signed [STEP_W-1:0]  step_w;
    logic [ACC_W-1:0]          unw_sum;
    logic [ACC_W-1:0]          diff_a;
    logic signed [PROD_W-1:0]  prod_sh;
    logic [ACC_W-1:0]          afv_sum;
    logic signed [SPEED_W-1:0] d0;
    logic signed [SPEED_W-1:0] d_w;
    logic signed [SPEED_W:0]   diff_s;
    logic signed [ACC_W-1:0]   v_sum;
    logic signed [SPEED_W-1:0] v_sat;
    logic [COEF_W-1:0]         alpha_sel;

    eauf_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // handshakes
    assign in_ch.ready = (ctrl.op == OP_FETCH);
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign out_busy    = out_valid_reg && !out_ch.ready;
    assign emit_load   = (ctrl.op == OP_EMIT) && !out_busy;
    assign warming     = warm_cnt_reg < warmup_samples_reg;

    assign status = '{in_accept: in_accept, first: first_reg,
                      warming: warming, out_busy: out_busy};

    assign raw_in = {in_ch.angle_high_byte[3:0] & NIBBLE_MASK, in_ch.angle_low_byte};

    // unwrap the raw step across the half-turn; +-4096 is a flip of the top bit
    always_comb
    begin
        raw_step = $signed({1'b0, raw_reg}) - $signed({1'b0, prev_raw_reg});
        if (raw_step > $signed(13'sd2048) || raw_step < $signed(-13'sd2048))
            step_w = {~raw_step[STEP_W-1], raw_step[STEP_W-2:0]};
        else
            step_w = raw_step;
    end

    assign unw_sum = unw_reg + {{(ACC_W-STEP_W-8){step_w[STEP_W-1]}}, step_w, 8'h00};
    assign diff_a  = unw_sum - afv_reg;

    // floor of alpha * diff over 2^ALPHA_BITS
    assign prod_sh = prod_reg >>> ALPHA_BITS;
    assign afv_sum = afv_reg + prod_sh[ACC_W-1:0];

    // speed delta wrapped to one half-turn each way; +-2^20 flips the top bit
    always_comb
    begin
        d0 = $signed({1'b0, filt_reg}) - $signed({1'b0, prev_filt_reg});
        if (d0 > $signed(21'sd524288) || d0 < $signed(-21'sd524288))
            d_w = {~d0[SPEED_W-1], d0[SPEED_W-2:0]};
        else
            d_w = d0;
        diff_s = {d_w[SPEED_W-1], d_w} - {sfv_reg[SPEED_W-1], sfv_reg};
    end

    // speed filter update with saturation to one half-turn
    always_comb
    begin
        v_sum = {{(ACC_W-SPEED_W){sfv_reg[SPEED_W-1]}}, sfv_reg} + $signed(prod_sh[ACC_W-1:0]);
        if (v_sum > $signed(32'sd524288))
            v_sat = 21'sd524288;
        else if (v_sum < $signed(-32'sd524288))
            v_sat = -21'sd524288;
        else
            v_sat = v_sum[SPEED_W-1:0];
    end

    assign alpha_sel = (ctrl.op == OP_MUL_S) ? speed_alpha_reg : angle_alpha_reg;

    // configuration writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_alpha_reg    <= ANGLE_ALPHA_RST;
            speed_alpha_reg    <= SPEED_ALPHA_RST;
            warmup_samples_reg <= WARMUP_SAMPLES_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ANGLE_ALPHA:    angle_alpha_reg    <= cfg_wr_data[COEF_W-1:0];
                REG_SPEED_ALPHA:    speed_alpha_reg    <= cfg_wr_data[COEF_W-1:0];
                REG_WARMUP_SAMPLES: warmup_samples_reg <= cfg_wr_data[WARM_W-1:0];
                default:            ;
            endcase
        end
    end

    // control state of the filters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= 1'b1;
            sfv_reg       <= '0;
            warm_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.op == OP_UNWRAP)
                first_reg <= 1'b0;
            if (ctrl.op == OP_WARM && warming)
                warm_cnt_reg <= warm_cnt_reg + 1'b1;
            if (ctrl.op == OP_ACC_S)
                sfv_reg <= v_sat;
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers, every one written before it is read
    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_FETCH:
            begin
                if (in_accept)
                    raw_reg <= raw_in;
            end
            OP_UNWRAP:
            begin
                prev_raw_reg <= raw_reg;
                if (first_reg)
                begin
                    // first sample seeds the whole angle chain
                    unw_reg       <= {{(ACC_W-RAW_W-8){1'b0}}, raw_reg, 8'h00};
                    afv_reg       <= {{(ACC_W-RAW_W-8){1'b0}}, raw_reg, 8'h00};
                    filt_reg      <= {raw_reg, 8'h00};
                    prev_filt_reg <= {raw_reg, 8'h00};
                end
                else
                begin
                    unw_reg <= unw_sum;
                    x_reg   <= $signed(diff_a);
                end
            end
            OP_MUL_A, OP_MUL_S:
            begin
                prod_reg <= $signed({1'b0, alpha_sel}) * x_reg;
            end
            OP_ACC_A:
            begin
                afv_reg  <= afv_sum;
                filt_reg <= afv_sum[TURN_W-1:0];
            end
            OP_WARM:
            begin
                spd_ok_reg <= !warming;
                x_reg      <= {{(ACC_W-SPEED_W-1){diff_s[SPEED_W]}}, diff_s};
            end
            OP_ACC_S:
            begin
                // speed register itself lives with the reset state
            end
            OP_EMIT:
            begin
                if (emit_load)
                begin
                    out_angle_reg  <= filt_reg;
                    out_speed_reg  <= sfv_reg;
                    out_spd_ok_reg <= spd_ok_reg;
                    prev_filt_reg  <= filt_reg;
                end
            end
        endcase
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.filtered_angle = out_angle_reg;
    assign out_ch.filtered_speed = out_speed_reg;
    assign out_ch.speed_valid    = out_spd_ok_reg;

    // a taken sample moves the program off the fetch step at once
    a_fetch_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ch.ready)
        else $error("sequencer stayed on fetch after a transaction");

    // speed filter never leaves its saturation range
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sfv_reg <= $signed(21'sd524288)) && (sfv_reg >= $signed(-21'sd524288)))
        else $error("speed filter out of range");

    // seed flag drops only through the unwrap step
    a_seed_once: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_reg) |-> $past(ctrl.op == OP_UNWRAP))
        else $error("seed flag cleared outside unwrap");

    // a result appears only after the emit step
    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.op == OP_EMIT))
        else $error("result raised outside emit");

endmodule
